// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, codes and structures of the double-ended queue with a
// clamped offset read.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int SUM_W   = PTR_W + 1;
    localparam int CNT_W   = 7;
    localparam int OFF_W   = 16;
    localparam int DATA_W  = 32;
    localparam int CMP_W   = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;

    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_MOVE       = 3'd4
    } req_type_t;

    typedef enum logic [1:0] {
        DIR_OTHER = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_STEP  = 2'd3
    } status_t;

    typedef struct packed {
        logic                     wr_en;
        logic [PTR_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic                     rd_en;
        logic [PTR_W-1:0]         rd_addr;
    } deq_mem_req_t;

    typedef struct packed {
        status_t          status;
        logic             read_valid;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
    } deq_res_t;

endpackage

// ===== design/deque_with_clamped_offset_read.sv =====
// ----------------------------------------------------------------------------
// Deque with clamped offset read
// Double-ended queue of signed 32-bit entries in a ring, with push and pop at
// both ends and a step offset that reads one entry on the final step.
//
//   Channel  Prefix  Carries
//   input    s_      request: type, push value, direction, last step
//   result   m_      status, read valid, read value, entry count, empty flag
//
// Each result is registered when its request is accepted and shows in the
// next cycle; a new request is taken every cycle unless the result stalls.
// The single write port and registered read port of the store allow this.
// Reset clears the front pointer, count and offset, not the entry store. A
// stalled result holds the output register and new requests until it frees.
// ----------------------------------------------------------------------------
module deque_with_clamped_offset_read
    import deq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_req_type,
    input  logic signed [DATA_W-1:0] s_push_value,
    input  logic [1:0]               s_direction,
    input  logic                     s_last_step,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic                     m_read_valid,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [CNT_W-1:0]         m_entry_count,
    output logic                     m_is_empty
);

    logic                     accept;
    logic                     m_valid_reg;
    deq_mem_req_t             mem_req;
    deq_res_t                 res;
    deq_res_t                 res_reg;
    logic signed [DATA_W-1:0] rd_data;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    deq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req_type   (s_req_type),
        .push_value (s_push_value),
        .direction  (s_direction),
        .last_step  (s_last_step),
        .mem_req    (mem_req),
        .res        (res)
    );

    deq_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_read_valid  = res_reg.read_valid;
    assign m_read_value  = res_reg.read_valid ? rd_data : '0;
    assign m_entry_count = res_reg.entry_count;
    assign m_is_empty    = res_reg.is_empty;

    a_empty_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_entry_count == '0)))
        else $error("Empty flag disagrees with the entry count.");

    a_read_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_valid) |-> ((m_status == ST_OK) && (m_entry_count != '0)))
        else $error("Read reported on an empty queue or with a bad status.");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CNT_W'(DEPTH)))
        else $error("Entry count exceeds the queue depth.");

    a_step_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_STEP || m_status == ST_FULL)) |-> !m_read_valid)
        else $error("Read reported on a request that cannot read.");

endmodule

// ===== design/deq_store.sv =====
// ----------------------------------------------------------------------------
// Deque entry store
// Ring memory of queue entries with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module deq_store
    import deq_pkg::*;
(
    input  logic                     aclk,
    input  deq_mem_req_t             mem_req,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque control
// Holds the front pointer, entry count and step offset, decodes each request
// and drives the entry store and the result fields.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic [1:0]               direction,
    input  logic                     last_step,
    output deq_mem_req_t             mem_req,
    output deq_res_t                 res
);

    logic [PTR_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [OFF_W-1:0] off_reg, off_next;

    logic                    full, empty;
    logic [PTR_W-1:0]        front_dec, front_inc, back_addr, pos;
    logic [SUM_W-1:0]        back_sum, rd_sum;
    logic signed [OFF_W-1:0] off_step;
    logic signed [CMP_W-1:0] off_ext, cnt_ext;
    logic                    wr_en, rd_en;
    logic [PTR_W-1:0]        wr_addr;

    assign full  = (count_reg >= CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);

    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_addr = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(back_sum);

    always_comb begin
        off_step = off_reg;
        case (dir_t'(direction))
            DIR_LEFT:  if (off_reg != OFF_MIN) off_step = off_reg - OFF_W'(1);
            DIR_RIGHT: if (off_reg != OFF_MAX) off_step = off_reg + OFF_W'(1);
            default:   off_step = off_reg;
        endcase
    end

    assign off_ext = CMP_W'(off_step);
    assign cnt_ext = signed'(CMP_W'(count_reg));

    always_comb begin
        if (off_ext <= CMP_W'(0)) begin
            pos = '0;
        end else if (off_ext >= cnt_ext) begin
            pos = PTR_W'(count_reg - CNT_W'(1));
        end else begin
            pos = PTR_W'(off_ext);
        end
    end

    assign rd_sum = SUM_W'(front_reg) + SUM_W'(pos);

    always_comb begin
        front_next     = front_reg;
        count_next     = count_reg;
        off_next       = off_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = back_addr;
        res.status     = ST_OK;
        res.read_valid = 1'b0;
        unique case (req_type_t'(req_type))
            REQ_PUSH_FRONT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    front_next = front_dec;
                    wr_addr    = front_dec;
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_MOVE: begin
                off_next = off_step;
                if (!last_step) begin
                    res.status = ST_STEP;
                end else begin
                    if (empty) begin
                        res.status = ST_EMPTY;
                    end else begin
                        rd_en          = 1'b1;
                        res.read_valid = 1'b1;
                    end
                    off_next = '0;
                end
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
        res.entry_count = count_next;
        res.is_empty    = (count_next == '0);
    end

    assign mem_req.wr_en   = accept && wr_en;
    assign mem_req.wr_addr = wr_addr;
    assign mem_req.wr_data = push_value;
    assign mem_req.rd_en   = accept && rd_en;
    assign mem_req.rd_addr = (rd_sum >= SUM_W'(DEPTH)) ? PTR_W'(rd_sum - SUM_W'(DEPTH))
                                                       : PTR_W'(rd_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            off_reg   <= '0;
        end else if (accept) begin
            front_reg <= front_next;
            count_reg <= count_next;
            off_reg   <= off_next;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deque testbench
// Sends push, pop, step and undefined requests into the deque with clamped
// offset read, predicts every result from a ring model kept here, checks each
// result field by field and stalls both channels at random in two phases.
// ----------------------------------------------------------------------------
module testbench;
    import deq_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
        logic [1:0]               dir;
        logic                     last;
    } request_t;

    typedef struct {
        status_t                  status;
        logic                     read_valid;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } deq_result_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_req_type    = '0;
    logic signed [DATA_W-1:0] s_push_value  = '0;
    logic [1:0]               s_direction   = '0;
    logic                     s_last_step   = 1'b0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [1:0]               m_status;
    logic                     m_read_valid;
    logic signed [DATA_W-1:0] m_read_value;
    logic [CNT_W-1:0]         m_entry_count;
    logic                     m_is_empty;

    request_t    pending_requests[$];
    deq_result_t expected_results[$];
    request_t    next_request;
    deq_result_t oldest_result;

    logic signed [DATA_W-1:0] model_ring[DEPTH];
    logic [PTR_W-1:0]         model_front  = '0;
    logic [CNT_W-1:0]         model_count  = '0;
    logic signed [OFF_W-1:0]  model_offset = '0;

    int send_idle_pct = 13;
    int recv_idle_pct = 65;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int fill_level    = 0;

    deque_with_clamped_offset_read u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_push_value  (s_push_value),
        .s_direction   (s_direction),
        .s_last_step   (s_last_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_valid  (m_read_valid),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch in %s: got %0h, expected %0h", field, got, want);
        mismatches++;
    endtask

    task automatic predict_request(input logic [2:0] kind,
                                   input logic signed [DATA_W-1:0] value,
                                   input logic [1:0] dir, input logic last);
        deq_result_t      res;
        logic [PTR_W-1:0] slot;
        int               pos;
        res.status     = ST_OK;
        res.read_valid = 1'b0;
        res.read_value = '0;
        case (kind)
            REQ_PUSH_FRONT: begin
                if (model_count == CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    model_front = model_front - PTR_W'(1);
                    model_ring[model_front] = value;
                    model_count++;
                end
            end
            REQ_PUSH_BACK: begin
                if (model_count == CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    slot = model_front + model_count[PTR_W-1:0];
                    model_ring[slot] = value;
                    model_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (model_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_front = model_front + PTR_W'(1);
                    model_count--;
                end
            end
            REQ_POP_BACK: begin
                if (model_count == '0) res.status = ST_EMPTY;
                else model_count--;
            end
            REQ_MOVE: begin
                if (dir == DIR_LEFT && model_offset != OFF_MIN) model_offset--;
                else if (dir == DIR_RIGHT && model_offset != OFF_MAX) model_offset++;
                if (!last) begin
                    res.status = ST_STEP;
                end else begin
                    if (model_count == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        if (model_offset <= OFF_W'(0)) pos = 0;
                        else if (int'(model_offset) >= int'(model_count))
                            pos = int'(model_count) - 1;
                        else pos = int'(model_offset);
                        slot = model_front + pos[PTR_W-1:0];
                        res.read_valid = 1'b1;
                        res.read_value = model_ring[slot];
                    end
                    model_offset = '0;
                end
            end
            default: ;
        endcase
        res.entry_count = model_count;
        res.is_empty    = (model_count == '0);
        expected_results.push_back(res);
    endtask

    // The fill level steers the random bursts toward a full or an empty queue.
    task automatic add_req(input logic [2:0] kind, input logic signed [DATA_W-1:0] value,
                           input logic [1:0] dir, input logic last);
        request_t r;
        r.kind  = kind;
        r.value = value;
        r.dir   = dir;
        r.last  = last;
        pending_requests.push_back(r);
        if ((kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) && fill_level < DEPTH)
            fill_level++;
        else if ((kind == REQ_POP_FRONT || kind == REQ_POP_BACK) && fill_level > 0)
            fill_level--;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_direction(input int lean);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return DIR_OTHER;
        if (r == 1) return 2'd3;
        if (lean == 0) return (r < 16) ? DIR_LEFT : DIR_RIGHT;
        if (lean == 1) return (r < 16) ? DIR_RIGHT : DIR_LEFT;
        return r[0] ? DIR_LEFT : DIR_RIGHT;
    endfunction

    task automatic add_random_requests(input int target);
        int made;
        int burst;
        int steps;
        int lean;
        int extra;
        made = 0;
        while (made < target) begin
            burst = $urandom_range(0, 9);
            if (burst <= 1) begin
                extra = $urandom_range(1, 3);
                while (fill_level < DEPTH) begin
                    add_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                            pick_value(), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
                    made++;
                end
                repeat (extra) add_req(REQ_PUSH_BACK, pick_value(), DIR_OTHER, 1'b0);
                made += extra;
            end else if (burst <= 3) begin
                extra = $urandom_range(1, 2);
                while (fill_level > 0) begin
                    add_req($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT,
                            pick_value(), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
                    made++;
                end
                repeat (extra) add_req(REQ_POP_FRONT, pick_value(), DIR_OTHER, 1'b0);
                made += extra;
            end else if (burst <= 6) begin
                steps = $urandom_range(0, 70);
                lean  = $urandom_range(0, 2);
                repeat (steps) add_req(REQ_MOVE, pick_value(), pick_direction(lean), 1'b0);
                add_req(REQ_MOVE, pick_value(), 2'($urandom_range(0, 3)), 1'b1);
                made += steps + 1;
            end else if (burst <= 8) begin
                steps = $urandom_range(1, 10);
                repeat (steps) add_req(3'($urandom_range(0, 3)), pick_value(),
                                       2'($urandom_range(0, 3)),
                                       1'($urandom_range(0, 1)));
                made += steps;
            end else begin
                add_req(3'($urandom_range(0, 7)), $urandom, 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    task automatic add_directed_requests();
        add_req(REQ_POP_FRONT, '0, DIR_OTHER, 1'b0);
        add_req(REQ_POP_BACK, '0, DIR_OTHER, 1'b1);
        add_req(REQ_MOVE, '0, DIR_RIGHT, 1'b1);
        add_req(REQ_PUSH_FRONT, 32'sh8000_0000, DIR_OTHER, 1'b0);
        add_req(REQ_PUSH_BACK, 32'sh7fff_ffff, DIR_LEFT, 1'b0);
        add_req(REQ_PUSH_FRONT, '0, DIR_RIGHT, 1'b1);
        add_req(REQ_PUSH_BACK, -32'sd1, 2'd3, 1'b1);
        add_req(REQ_MOVE, '0, DIR_LEFT, 1'b0);
        add_req(REQ_MOVE, '0, DIR_LEFT, 1'b1);
        add_req(REQ_MOVE, '0, DIR_OTHER, 1'b0);
        add_req(REQ_MOVE, '0, 2'd3, 1'b0);
        add_req(REQ_MOVE, '0, DIR_RIGHT, 1'b1);
        repeat (5) add_req(REQ_MOVE, '0, DIR_RIGHT, 1'b0);
        add_req(REQ_MOVE, '0, DIR_RIGHT, 1'b1);
        add_req(3'd5, 32'sh5555_5555, DIR_LEFT, 1'b1);
        add_req(3'd6, 32'shaaaa_aaaa, DIR_RIGHT, 1'b0);
        add_req(3'd7, -32'sd1, 2'd3, 1'b1);
        add_req(REQ_POP_FRONT, '0, DIR_OTHER, 1'b1);
        add_req(REQ_POP_BACK, '0, DIR_OTHER, 1'b0);
        add_req(REQ_MOVE, '0, DIR_OTHER, 1'b1);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_request(s_req_type, s_push_value, s_direction, s_last_step);
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_req_type   <= next_request.kind;
                    s_push_value <= next_request.value;
                    s_direction  <= next_request.dir;
                    s_last_step  <= next_request.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 32'(m_status), 0);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_status !== oldest_result.status)
                        report_mismatch("status", 32'(m_status),
                                        32'(oldest_result.status));
                    if (m_read_valid !== oldest_result.read_valid)
                        report_mismatch("read_valid", 32'(m_read_valid),
                                        32'(oldest_result.read_valid));
                    if (m_read_value !== oldest_result.read_value)
                        report_mismatch("read_value", m_read_value, oldest_result.read_value);
                    if (m_entry_count !== oldest_result.entry_count)
                        report_mismatch("entry_count", 32'(m_entry_count),
                                        32'(oldest_result.entry_count));
                    if (m_is_empty !== oldest_result.is_empty)
                        report_mismatch("is_empty", 32'(m_is_empty),
                                        32'(oldest_result.is_empty));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 65;
        add_directed_requests();
        add_random_requests(200);
        while (pending_requests.size() != 0) @(posedge aclk);

        send_idle_pct = 65;
        recv_idle_pct = 13;
        add_random_requests(200);
        while (pending_requests.size() != 0) @(posedge aclk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_requests(200);
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
